@@ rtl/lcsu_pkg.sv @@
// ----------------------------------------------------------------------------
// LSTM cell update package
// Shared widths, beat types, the sigmoid and tanh tables and the saturation
// helper. The tables are built at elaboration from an exact integer series.
// ----------------------------------------------------------------------------
package lcsu_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 12;
	localparam int TABLE_BITS = 8;

	localparam int ARG_SHIFT = FRAC_BITS + TABLE_BITS - DATA_WIDTH;
	localparam int TSIZE     = 1 << TABLE_BITS;
	// Table entries span -1.0 .. +1.0 in the fraction format.
	localparam int TAB_W     = FRAC_BITS + 2;
	// Full widths of the forget and input products and the width of the cell sum.
	localparam int PF_W      = TAB_W + DATA_WIDTH;
	localparam int PI_W      = 2 * TAB_W;
	localparam int SUM_W     = PF_W - FRAC_BITS + 1;

	localparam logic [63:0] EXP_ONE = 64'd1 << 30;
	localparam logic [63:0] FX_ONE  = 64'd1 << FRAC_BITS;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [TAB_W-1:0]      tab_word_t;
	typedef tab_word_t [TSIZE-1:0]        tab_t;
	typedef logic [TABLE_BITS-1:0]        tab_addr_t;

	// What the cell path hands to the hidden path.
	typedef struct packed {
		data_t     cell_val;
		tab_word_t out_gate;
	} cell_beat_t;

	// Restoring division; only used while the tables are built.
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^(k / 2^shift) in Q30 by the power series.
	function automatic logic [63:0] exp_q30(input logic [63:0] k, input int shift);
		logic [63:0] sum;
		logic [63:0] term;
		int          n;
		sum  = '0;
		term = EXP_ONE;
		n    = 1;
		while (n < 400 && term != 64'd0) begin
			sum  = sum + term;
			term = long_div((term * k) >> shift, 64'(n));
			n    = n + 1;
		end
		return sum;
	endfunction

	// Round half up of num * 2^FRAC_BITS / den, for num <= den.
	function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = num;
		for (int i = 0; i <= FRAC_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

	function automatic tab_t build_tab(input logic is_tanh);
		tab_t        tab;
		int          shift;
		logic [63:0] limit;
		logic [63:0] mag;
		logic [63:0] e;
		logic [63:0] val;
		logic        neg;
		shift = is_tanh ? ARG_SHIFT - 1 : ARG_SHIFT;
		limit = 64'd16 << shift;
		for (int a = 0; a < TSIZE; a++) begin
			neg = (a >= TSIZE / 2);
			mag = neg ? 64'(TSIZE - a) : 64'(a);
			if (mag > limit) begin
				if (is_tanh)
					val = neg ? -FX_ONE : FX_ONE;
				else
					val = neg ? 64'd0 : FX_ONE;
			end else begin
				e = exp_q30(mag, shift);
				if (is_tanh) begin
					val = frac_div(e - EXP_ONE, e + EXP_ONE);
					if (neg)
						val = -val;
				end else begin
					val = neg ? frac_div(EXP_ONE, e + EXP_ONE) : frac_div(e, e + EXP_ONE);
				end
			end
			tab[a] = TAB_W'(val);
		end
		return tab;
	endfunction

	localparam tab_t SIG_TAB  = build_tab(1'b0);
	localparam tab_t TANH_TAB = build_tab(1'b1);

	// The table address is the top bits of the operand.
	function automatic tab_addr_t tab_addr(input data_t x);
		return x[DATA_WIDTH-1 -: TABLE_BITS];
	endfunction

	function automatic data_t sat_data(input logic signed [SUM_W-1:0] v);
		if (v > SAT_HI)
			return DATA_WIDTH'(SAT_HI);
		else if (v < SAT_LO)
			return DATA_WIDTH'(SAT_LO);
		return DATA_WIDTH'(v);
	endfunction

endpackage

@@ rtl/lcsu_cell_path.sv @@
// ----------------------------------------------------------------------------
// LSTM cell path
// Three stages: gate table lookups, the two rounded products, then the
// saturated cell sum. Each stage holds its beat while the next one is full and held.
// ----------------------------------------------------------------------------
module lcsu_cell_path (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lcsu_pkg::data_t      pre_input_gate,
	input  lcsu_pkg::data_t      pre_forget_gate,
	input  lcsu_pkg::data_t      pre_output_gate,
	input  lcsu_pkg::data_t      pre_candidate,
	input  lcsu_pkg::data_t      cell_prev,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lcsu_pkg::cell_beat_t out_beat
);
	import lcsu_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	tab_word_t si_s1, sf_s1, so_s1, tg_s1;
	data_t     c_s1;

	logic signed [PF_W-FRAC_BITS-1:0] pf_s2;
	logic signed [PI_W-FRAC_BITS-1:0] pi_s2;
	tab_word_t                        so_s2;

	cell_beat_t beat_s3;

	logic signed [PF_W-1:0]  pf_full;
	logic signed [PI_W-1:0]  pi_full;
	logic signed [SUM_W-1:0] cell_sum;

	// A stage takes a new beat when it is empty or its beat moves on.
	assign rdy_s3   = !v_s3 || !out_stall;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= in_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_s3)
				v_s3 <= v_s2;
		end
	end

	// Products rounded half up: add half an LSB, keep the upper bits.
	assign pf_full  = $signed(sf_s1) * $signed(c_s1) + PF_W'(1 << (FRAC_BITS - 1));
	assign pi_full  = $signed(si_s1) * $signed(tg_s1) + PI_W'(1 << (FRAC_BITS - 1));
	assign cell_sum = SUM_W'(pf_s2) + SUM_W'(pi_s2);

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			si_s1 <= SIG_TAB[tab_addr(pre_input_gate)];
			sf_s1 <= SIG_TAB[tab_addr(pre_forget_gate)];
			so_s1 <= SIG_TAB[tab_addr(pre_output_gate)];
			tg_s1 <= TANH_TAB[tab_addr(pre_candidate)];
			c_s1  <= cell_prev;
		end
		if (rdy_s2) begin
			pf_s2 <= pf_full[PF_W-1:FRAC_BITS];
			pi_s2 <= pi_full[PI_W-1:FRAC_BITS];
			so_s2 <= so_s1;
		end
		if (rdy_s3) begin
			beat_s3.cell_val <= sat_data(cell_sum);
			beat_s3.out_gate <= so_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_beat  = beat_s3;

`ifndef SYNTH
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_stall))
		else $error("cell path stalls its input with an empty stage");

	a_blocked_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy_s2) |=> (v_s2 && $stable(pf_s2) && $stable(pi_s2)))
		else $error("blocked product stage lost its beat");

	a_drain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !out_stall && !v_s2) |=> !v_s3)
		else $error("delivered cell beat was repeated");
`endif

endmodule

@@ rtl/lcsu_hidden_path.sv @@
// ----------------------------------------------------------------------------
// LSTM hidden path
// Two stages: tanh lookup of the new cell value, then the rounded product
// with the output gate. The second stage is the output register.
// ----------------------------------------------------------------------------
module lcsu_hidden_path (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lcsu_pkg::cell_beat_t in_beat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lcsu_pkg::data_t      cell_next,
	output lcsu_pkg::data_t      hidden_next
);
	import lcsu_pkg::*;

	logic v_s4, v_s5;
	logic rdy_s4, rdy_s5;

	data_t     cn_s4;
	tab_word_t so_s4;
	tab_word_t tc_s4;
	data_t     cn_s5;
	data_t     h_s5;

	logic signed [PI_W-1:0] hp_full;

	assign rdy_s5   = !v_s5 || !out_stall;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_stall = !rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4)
				v_s4 <= in_valid;
			if (rdy_s5)
				v_s5 <= v_s4;
		end
	end

	assign hp_full = $signed(so_s4) * $signed(tc_s4) + PI_W'(1 << (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			cn_s4 <= in_beat.cell_val;
			so_s4 <= in_beat.out_gate;
			tc_s4 <= TANH_TAB[tab_addr(in_beat.cell_val)];
		end
		if (rdy_s5) begin
			cn_s5 <= cn_s4;
			h_s5  <= sat_data(SUM_W'($signed(hp_full[PI_W-1:FRAC_BITS])));
		end
	end

	assign out_valid   = v_s5;
	assign cell_next   = cn_s5;
	assign hidden_next = h_s5;

`ifndef SYNTH
	a_lookup_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !rdy_s4) |=> (v_s4 && $stable(tc_s4) && $stable(cn_s4)))
		else $error("blocked lookup stage lost its beat");

	a_no_beat_from_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s4 && !(v_s5 && out_stall)) |=> !v_s5)
		else $error("result appeared without a beat in flight");
`endif

endmodule

@@ rtl/lstm_cell_state_update.sv @@
// ----------------------------------------------------------------------------
// LSTM cell state update
// Per element: c' = sig(f)*c + sig(i)*tanh(g), h = sig(o)*tanh(c'), Q4.12,
// table activations, products rounded half up, results saturated.
//
//   channel  dir  handshake            beat fields
//   in       in   in_valid, in_stall   pre_input_gate, pre_forget_gate,
//                                      pre_output_gate, pre_candidate, cell_prev
//   out      out  out_valid, out_stall cell_next, hidden_next
//
// One beat enters per cycle while in_stall is low; each beat passes the five
// register stages (lookup, products, cell sum, tanh lookup, hidden product).
// Reset clears only the stage valid bits; the tables are constant logic. A
// stall on the output holds the full stages and lets empty stages ahead of it
// fill, so in_stall rises only when all are full.
// ----------------------------------------------------------------------------
module lstm_cell_state_update (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lcsu_pkg::data_t pre_input_gate,
	input  lcsu_pkg::data_t pre_forget_gate,
	input  lcsu_pkg::data_t pre_output_gate,
	input  lcsu_pkg::data_t pre_candidate,
	input  lcsu_pkg::data_t cell_prev,
	output logic            out_valid,
	input  logic            out_stall,
	output lcsu_pkg::data_t cell_next,
	output lcsu_pkg::data_t hidden_next
);
	import lcsu_pkg::*;

	logic       mid_valid;
	logic       mid_stall;
	cell_beat_t mid_beat;

	lcsu_cell_path u_cell (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pre_input_gate  (pre_input_gate),
		.pre_forget_gate (pre_forget_gate),
		.pre_output_gate (pre_output_gate),
		.pre_candidate   (pre_candidate),
		.cell_prev       (cell_prev),
		.out_valid       (mid_valid),
		.out_stall       (mid_stall),
		.out_beat        (mid_beat)
	);

	lcsu_hidden_path u_hidden (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (mid_valid),
		.in_stall    (mid_stall),
		.in_beat     (mid_beat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_next   (cell_next),
		.hidden_next (hidden_next)
	);

`ifndef SYNTH
	// The hidden value is a product of two unit-bounded factors.
	a_hidden_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(hidden_next) <= $signed(DATA_WIDTH'(1 << FRAC_BITS)) &&
			$signed(hidden_next) >= -$signed(DATA_WIDTH'(1 << FRAC_BITS))))
		else $error("hidden output outside the unit range");
`endif

endmodule

@@ dv/lstm_update_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LSTM cell update checker
// Watches both channels of the cell update block. For every input beat it
// predicts the cell and hidden values, using sigmoid and tanh tables that it
// builds itself from an exact integer series. Each output beat is compared,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module lstm_update_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  lcsu_pkg::data_t pre_input_gate,
	input  lcsu_pkg::data_t pre_forget_gate,
	input  lcsu_pkg::data_t pre_output_gate,
	input  lcsu_pkg::data_t pre_candidate,
	input  lcsu_pkg::data_t cell_prev,
	input  logic            out_valid,
	input  logic            out_stall,
	input  lcsu_pkg::data_t cell_next,
	input  lcsu_pkg::data_t hidden_next,
	input  logic            drain_done,
	output int              pending,
	output int              fail_count
);

	localparam int DW       = lcsu_pkg::DATA_WIDTH;
	localparam int FB       = lcsu_pkg::FRAC_BITS;
	localparam int TB       = lcsu_pkg::TABLE_BITS;
	localparam int LUT_SIZE = 1 << TB;
	// One table step is 2^-STEP_LOG in sigmoid argument units.
	localparam int STEP_LOG = FB + TB - DW;

	localparam longint unsigned Q30_ONE  = 64'd1 << 30;
	localparam longint          FX_ONE   = 64'sd1 <<< FB;
	localparam longint          DATA_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
	localparam longint          DATA_MIN = -DATA_MAX - 64'sd1;

	typedef struct packed {
		lcsu_pkg::data_t cell_val;
		lcsu_pkg::data_t hidden;
	} cell_hidden_t;

	int           sigmoid_lut [LUT_SIZE];
	int           tanh_lut [LUT_SIZE];
	cell_hidden_t cell_hidden_q [$];
	int           fault_count = 0;
	int           leftover_count = 0;
	int           out_beats = 0;

	assign fail_count = fault_count + leftover_count;

	// e^(k/d) in Q30; every term of the series is positive.
	function automatic longint unsigned exp_series_q30(input longint unsigned k,
			input longint unsigned d);
		longint unsigned sum;
		longint unsigned term;
		sum  = 0;
		term = Q30_ONE;
		for (int n = 1; n < 400 && term != 0; n++) begin
			sum  = sum + term;
			term = (term * k) / (d * 64'(n));
		end
		return sum;
	endfunction

	// num/den as a fraction with FB bits, rounded half up, for num <= den.
	function automatic int ratio_fx(input longint unsigned num, input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = num;
		for (int i = 0; i <= FB; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return int'((q + 64'd1) >> 1);
	endfunction

	function automatic int lut_index(input lcsu_pkg::data_t x);
		return int'(x[DW-1 -: TB]);
	endfunction

	function automatic longint round_mul(input longint a, input longint b);
		longint p;
		p = a * b + (64'sd1 <<< (FB - 1));
		return p >>> FB;
	endfunction

	function automatic longint clamp_data(input longint v);
		if (v > DATA_MAX)
			return DATA_MAX;
		if (v < DATA_MIN)
			return DATA_MIN;
		return v;
	endfunction

	function automatic cell_hidden_t predict_cell_hidden(input lcsu_pkg::data_t i_pre,
			f_pre, o_pre, g_pre, c_prev);
		cell_hidden_t res;
		longint       cell_sum;
		longint       hid;
		cell_sum = clamp_data(round_mul(sigmoid_lut[lut_index(f_pre)], c_prev)
			+ round_mul(sigmoid_lut[lut_index(i_pre)], tanh_lut[lut_index(g_pre)]));
		res.cell_val = cell_sum[DW-1:0];
		// The hidden value reads tanh of the saturated cell value.
		hid = clamp_data(round_mul(sigmoid_lut[lut_index(o_pre)],
			tanh_lut[lut_index(res.cell_val)]));
		res.hidden = hid[DW-1:0];
		return res;
	endfunction

	task automatic log_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t checker: %s", $time, what);
	endtask

	initial begin
		longint unsigned sig_div;
		longint unsigned tanh_div;
		longint unsigned mag;
		longint unsigned e;
		int              t;
		bit              neg;
		sig_div  = 64'd1 << STEP_LOG;
		tanh_div = 64'd1 << (STEP_LOG - 1);
		for (int a = 0; a < LUT_SIZE; a++) begin
			neg = (a >= LUT_SIZE / 2);
			mag = neg ? 64'(LUT_SIZE - a) : 64'(a);
			if (mag > 16 * sig_div) begin
				sigmoid_lut[a] = neg ? 0 : int'(FX_ONE);
			end else begin
				e = exp_series_q30(mag, sig_div);
				sigmoid_lut[a] = neg ? ratio_fx(Q30_ONE, e + Q30_ONE) : ratio_fx(e, e + Q30_ONE);
			end
			if (mag > 16 * tanh_div) begin
				tanh_lut[a] = neg ? -int'(FX_ONE) : int'(FX_ONE);
			end else begin
				e = exp_series_q30(mag, tanh_div);
				t = ratio_fx(e - Q30_ONE, e + Q30_ONE);
				tanh_lut[a] = neg ? -t : t;
			end
		end
	end

	always @(posedge clk) begin
		cell_hidden_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				cell_hidden_q = {cell_hidden_q, predict_cell_hidden(pre_input_gate,
					pre_forget_gate, pre_output_gate, pre_candidate, cell_prev)};
			if (out_valid && !out_stall) begin
				if (cell_hidden_q.size() == 0) begin
					log_fault($sformatf("beat %0d with nothing predicted: cell %0d hidden %0d",
						out_beats, cell_next, hidden_next));
				end else begin
					want = cell_hidden_q.pop_front();
					if (cell_next !== want.cell_val)
						log_fault($sformatf("beat %0d cell_next: expected %0d, got %0d",
							out_beats, want.cell_val, cell_next));
					if (hidden_next !== want.hidden)
						log_fault($sformatf("beat %0d hidden_next: expected %0d, got %0d",
							out_beats, want.hidden, hidden_next));
				end
				out_beats++;
			end
			pending <= cell_hidden_q.size();
		end
	end

	always @(posedge drain_done) begin
		if (cell_hidden_q.size() != 0) begin
			leftover_count = cell_hidden_q.size();
			$display("%0t checker: %0d predicted beats never came out", $time, leftover_count);
		end
	end

endmodule

@@ dv/tb_lstm_cell_state_update.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LSTM cell state update testbench
// Drives directed corner beats and then random beats into the cell update
// block with random gaps on the input and random stalls on the output. A
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_lstm_cell_state_update;

	localparam int DW           = lcsu_pkg::DATA_WIDTH;
	localparam int N_RANDOM     = 1750;
	localparam int IDLE_LIMIT   = 2000;
	// The block has five pipeline stages.
	localparam int DRAIN_CYCLES = 12;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	lcsu_pkg::data_t pre_input_gate = '0;
	lcsu_pkg::data_t pre_forget_gate = '0;
	lcsu_pkg::data_t pre_output_gate = '0;
	lcsu_pkg::data_t pre_candidate = '0;
	lcsu_pkg::data_t cell_prev = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	lcsu_pkg::data_t cell_next;
	lcsu_pkg::data_t hidden_next;
	logic            drain_done = 1'b0;
	int              pending;
	int              fail_count;
	bit              in_calm = 1'b0;
	bit              out_calm = 1'b0;
	int              stall_left = 0;
	int              idle_cycles = 0;

	lstm_cell_state_update dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pre_input_gate  (pre_input_gate),
		.pre_forget_gate (pre_forget_gate),
		.pre_output_gate (pre_output_gate),
		.pre_candidate   (pre_candidate),
		.cell_prev       (cell_prev),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cell_next       (cell_next),
		.hidden_next     (hidden_next)
	);

	lstm_update_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pre_input_gate  (pre_input_gate),
		.pre_forget_gate (pre_forget_gate),
		.pre_output_gate (pre_output_gate),
		.pre_candidate   (pre_candidate),
		.cell_prev       (cell_prev),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cell_next       (cell_next),
		.hidden_next     (hidden_next),
		.drain_done      (drain_done),
		.pending         (pending),
		.fail_count      (fail_count)
	);

	always #2 clk = ~clk;

	// Returns when the beat has been taken; valid stays high for the next call.
	task automatic send_beat(input int ig, input int fg, input int og, input int cg,
			input int cp);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		pre_input_gate  <= ig[DW-1:0];
		pre_forget_gate <= fg[DW-1:0];
		pre_output_gate <= og[DW-1:0];
		pre_candidate   <= cg[DW-1:0];
		cell_prev       <= cp[DW-1:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Half full range, the rest near the extremes, near zero, on table
	// boundaries or in the usual working range.
	function automatic int rand_q412();
		int v;
		case ($urandom_range(0, 9))
			5: begin
				case ($urandom_range(0, 4))
					0: v = 32767;
					1: v = -32768;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			6: v = int'($urandom_range(0, 1024)) - 512;
			7: v = int'(($urandom_range(0, 255) << 8) | ($urandom_range(0, 1) * 255));
			8, 9: v = int'($urandom_range(0, 16383)) - 8192;
			default: v = int'($urandom);
		endcase
		return v;
	endfunction

	always @(posedge clk) begin
		int draw;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				draw = out_calm ? 0 : $urandom_range(0, 13);
				out_stall  <= (draw != 0);
				stall_left <= draw;
			end else if (stall_left > 1) begin
				stall_left <= stall_left - 1;
			end else begin
				stall_left <= 0;
				out_stall  <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_lstm_cell_state_update: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(0, 0, 0, 0, 0);
		send_beat(32767, 32767, 32767, 32767, 32767);
		send_beat(32767, 32767, 32767, -32768, -32768);
		send_beat(-32768, -32768, -32768, -32768, -32768);
		// A forget gate of zero gives one half, so odd cell values land on ties.
		send_beat(-32768, 0, 0, 0, 1);
		send_beat(-32768, 0, 0, 0, -1);
		send_beat(-32768, 0, 0, 0, 3);
		send_beat(-32768, 0, 0, 0, -3);
		send_beat(32512, 32512, 32512, 32512, 4096);
		send_beat(-1, -1, -1, -1, -1);
		send_beat(255, 256, -256, -257, 8191);
		send_beat(1, -1, 255, -255, -8192);
		send_beat(-32768, 32767, 32767, 0, 32767);
		send_beat(-32768, 32767, 32767, 0, -32768);
		send_beat(16384, -16384, 4096, -4096, 12288);
		send_beat(-32513, 32767, -32768, 256, -256);
		send_beat(21845, -21846, 21845, -21846, 21845);
		send_beat(-21846, 21845, -21846, 21845, -21846);
		send_beat(0, 0, -32768, 32767, 0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 50 == 0) begin
				in_calm = ($urandom_range(0, 3) == 0);
				out_calm <= ($urandom_range(0, 3) == 0);
			end
			send_beat(rand_q412(), rand_q412(), rand_q412(), rand_q412(), rand_q412());
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		drain_done <= 1'b1;
		@(posedge clk);
		if (fail_count == 0)
			$display("tb_lstm_cell_state_update: done, clean");
		else
			$display("tb_lstm_cell_state_update: done, errors");
		$finish;
	end

endmodule
